### hdl/mlr_pkg.sv
// Package for the midpoint line rasterizer: coordinate widths, item structs,
// zone codes and the sequencer state type. No dependencies.
package mlr_pkg;

    localparam int COORD_BITS = 6;
    localparam int STEP_BITS  = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [2:0]            zone_t;

    localparam zone_t ZONE_ENE = 3'd0;
    localparam zone_t ZONE_NNE = 3'd1;
    localparam zone_t ZONE_NNW = 3'd2;
    localparam zone_t ZONE_WNW = 3'd3;
    localparam zone_t ZONE_WSW = 3'd4;
    localparam zone_t ZONE_SSW = 3'd5;
    localparam zone_t ZONE_SSE = 3'd6;
    localparam zone_t ZONE_ESE = 3'd7;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        zone_t  octant;
        logic   last;
    } pix_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAW
    } mlr_state_t;

endpackage

### hdl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: classifies a segment and walks it pixel by pixel.
// Depends on mlr_pkg for widths, item structs, zone codes and the state type.
//
// One segment item enters on seg and leaves as a run of pixel items on pix,
// from the start point to the end point inclusive, each tagged with the
// segment's zone (0..7 counterclockwise from +x, y up) and a last mark on the
// end pixel. A zero-length segment gives a single pixel in zone 1. The segment is
// captured while idle; in the setup state the zone, the major and minor lengths,
// the initial decision value and both decision increments are computed; then the
// draw state shows one pixel per cycle while pix is not stalled. The rate is set
// by the draw loop: a single decision adder and two coordinate steppers are reused
// once per pixel. seg_ready is high only while the sequencer is idle; the last pixel
// may still wait in the output register while the next segment is taken.
module midpoint_line_rasterizer
    import mlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      seg_valid,
    output logic      seg_ready,
    input  seg_item_t seg,
    output logic      pix_valid,
    input  logic      pix_ready,
    output pix_item_t pix
);

    // Control state
    mlr_state_t state_reg, state_next;
    logic       pix_valid_reg, pix_valid_next;

    // Datapath state
    seg_item_t                   seg_reg, seg_next;
    coord_t                      x_reg, x_next;
    coord_t                      y_reg, y_next;
    logic signed [DEC_BITS-1:0]  dec_reg, dec_next;
    logic signed [DEC_BITS-1:0]  inc_diag_reg, inc_diag_next;
    logic signed [DEC_BITS-1:0]  inc_axial_reg, inc_axial_next;
    logic [STEP_BITS-1:0]        steps_reg, steps_next;
    zone_t                       zone_reg, zone_next;
    logic                        xmajor_reg, xmajor_next;
    logic                        sx_neg_reg, sx_neg_next;
    logic                        sy_neg_reg, sy_neg_next;
    pix_item_t                   pix_reg, pix_next;

    // Setup arithmetic
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        ax, ay;
    logic                       x_wins;
    zone_t                      zone_c;
    logic                       xmajor_c;
    coord_t                     major_c, minor_c;

    // Draw step
    logic   emit;
    logic   diag;
    coord_t x_step, y_step;

    assign seg_ready = (state_reg == ST_IDLE);
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // The output slot is free, or is being emptied this cycle.
    assign emit = (state_reg == ST_DRAW) && (!pix_valid_reg || pix_ready);

    // Segment classification from the captured endpoints
    always_comb
    begin
        dx = $signed({1'b0, seg_reg.end_x}) - $signed({1'b0, seg_reg.start_x});
        dy = $signed({1'b0, seg_reg.end_y}) - $signed({1'b0, seg_reg.start_y});
        ax = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
        ay = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
        x_wins = (ax > ay);
        case ({dx[COORD_BITS], dy[COORD_BITS]})
            2'b00:   zone_c = x_wins ? ZONE_ENE : ZONE_NNE;
            2'b01:   zone_c = x_wins ? ZONE_ESE : ZONE_SSE;
            2'b11:   zone_c = x_wins ? ZONE_WSW : ZONE_SSW;
            2'b10:   zone_c = x_wins ? ZONE_WNW : ZONE_NNW;
            default: zone_c = ZONE_ENE;
        endcase
        xmajor_c = x_wins;
        major_c  = xmajor_c ? ax[COORD_BITS-1:0] : ay[COORD_BITS-1:0];
        minor_c  = xmajor_c ? ay[COORD_BITS-1:0] : ax[COORD_BITS-1:0];
    end

    // Tie goes diagonal in every zone.
    assign diag   = !dec_reg[DEC_BITS-1];
    assign x_step = x_reg + (sx_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
    assign y_step = y_reg + (sy_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (seg_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (emit && (steps_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        seg_next       = seg_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dec_next       = dec_reg;
        inc_diag_next  = inc_diag_reg;
        inc_axial_next = inc_axial_reg;
        steps_next     = steps_reg;
        zone_next      = zone_reg;
        xmajor_next    = xmajor_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        pix_next       = pix_reg;

        // Drop the shown pixel once taken.
        if (pix_valid_reg && pix_ready)
        begin
            pix_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (seg_valid)
                begin
                    seg_next = seg;
                end
            end
            ST_SETUP:
            begin
                x_next         = seg_reg.start_x;
                y_next         = seg_reg.start_y;
                zone_next      = zone_c;
                xmajor_next    = xmajor_c;
                sx_neg_next    = dx[COORD_BITS];
                sy_neg_next    = dy[COORD_BITS];
                steps_next     = {1'b0, major_c};
                dec_next       = $signed({2'b00, minor_c, 1'b0})
                               - $signed({3'b000, major_c});
                inc_diag_next  = $signed({2'b00, minor_c, 1'b0})
                               - $signed({2'b00, major_c, 1'b0});
                inc_axial_next = $signed({2'b00, minor_c, 1'b0});
            end
            ST_DRAW:
            begin
                if (emit)
                begin
                    // Show the current pixel, then advance one step.
                    pix_valid_next   = 1'b1;
                    pix_next.pixel_x = x_reg;
                    pix_next.pixel_y = y_reg;
                    pix_next.octant  = zone_reg;
                    pix_next.last    = (steps_reg == '0);
                    if (steps_reg != '0)
                    begin
                        steps_next = steps_reg - STEP_BITS'(1);
                        dec_next   = dec_reg + (diag ? inc_diag_reg : inc_axial_reg);
                        if (diag || xmajor_reg)
                        begin
                            x_next = x_step;
                        end
                        if (diag || !xmajor_reg)
                        begin
                            y_next = y_step;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg       <= seg_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        dec_reg       <= dec_next;
        inc_diag_reg  <= inc_diag_next;
        inc_axial_reg <= inc_axial_next;
        steps_reg     <= steps_next;
        zone_reg      <= zone_next;
        xmajor_reg    <= xmajor_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        pix_reg       <= pix_next;
    end

endmodule

### tb/midpoint_line_rasterizer_tb.sv
// Self-checking testbench for midpoint_line_rasterizer: segments in, pixel runs out.
// Depends on mlr_pkg for the item structs, coordinate widths and zone codes.
module midpoint_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlr_pkg::*;

    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    // Extra idle time after the last phase drains, before the result is printed.
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_STALL   = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      seg_valid = 1'b0;
    logic      seg_ready;
    seg_item_t seg = '0;
    logic      pix_valid;
    logic      pix_ready = 1'b0;
    pix_item_t pix;

    // Segments waiting to be offered, and pixels predicted but not yet seen.
    seg_item_t pending_segs[$];
    pix_item_t expected_pixels[$];

    // Idle percentages for each side, changed between phases.
    int unsigned tx_idle_pct = 29;
    int unsigned rx_idle_pct = 70;
    int unsigned mismatch_count = 0;

    // Long receiver hold-off: raised by the stimulus, counted down by its own process.
    logic        long_stall_go = 1'b0;
    logic        long_stall_done = 1'b0;
    int unsigned long_stall_count = 0;
    wire         rx_hold = long_stall_go && !long_stall_done;

    midpoint_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    always #5 clk = ~clk;

    // Walk one segment with the midpoint rule and queue every pixel it yields.
    // The same rule holds in all eight zones: start at d = 2*minor - major and
    // take a diagonal step whenever d >= 0, so a tie always goes diagonal.
    task automatic rasterize_segment(input seg_item_t s);
        int        dx;
        int        dy;
        int        ax;
        int        ay;
        int        sx;
        int        sy;
        int        major;
        int        minor;
        int        dec;
        int        x;
        int        y;
        zone_t     zone;
        bit        xmajor;
        pix_item_t p;
        dx = int'(s.end_x) - int'(s.start_x);
        dy = int'(s.end_y) - int'(s.start_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sx = (dx < 0) ? -1 : 1;
        sy = (dy < 0) ? -1 : 1;
        // Classify: an exact diagonal, and a zero-length segment, fall in the steep zone.
        if (dx >= 0 && dy >= 0)
            zone = (dx > dy) ? ZONE_ENE : ZONE_NNE;
        else if (dx >= 0)
            zone = (ax > ay) ? ZONE_ESE : ZONE_SSE;
        else if (dy < 0)
            zone = (ax > ay) ? ZONE_WSW : ZONE_SSW;
        else
            zone = (ax > ay) ? ZONE_WNW : ZONE_NNW;
        xmajor = (zone == ZONE_ENE) || (zone == ZONE_WNW) ||
                 (zone == ZONE_WSW) || (zone == ZONE_ESE);
        major = xmajor ? ax : ay;
        minor = xmajor ? ay : ax;
        dec = 2 * minor - major;
        x = int'(s.start_x);
        y = int'(s.start_y);
        for (int left = major; left >= 0; left--)
        begin
            p.pixel_x = coord_t'(x);
            p.pixel_y = coord_t'(y);
            p.octant  = zone;
            p.last    = (left == 0);
            expected_pixels.push_back(p);
            if (left == 0)
                break;
            if (dec >= 0)
            begin
                x += sx;
                y += sy;
                dec += 2 * (minor - major);
            end
            else
            begin
                if (xmajor)
                    x += sx;
                else
                    y += sy;
                dec += 2 * minor;
            end
        end
    endtask

    // Move a coordinate by an offset, mirroring the offset when it would leave the tile.
    function automatic coord_t offset_coord(input coord_t c, input int d);
        int v;
        v = int'(c) + d;
        if (v < 0 || v > COORD_MAX)
            v = int'(c) - d;
        return coord_t'(v);
    endfunction

    function automatic seg_item_t make_seg(input int x0, input int y0, input int x1, input int y1);
        seg_item_t s;
        s.start_x = coord_t'(x0);
        s.start_y = coord_t'(y0);
        s.end_x   = coord_t'(x1);
        s.end_y   = coord_t'(y1);
        return s;
    endfunction

    // Mix of fully random segments, short ones, axial, exact diagonal and
    // zero-length segments, so that every zone and step pattern shows up often.
    function automatic seg_item_t random_segment();
        seg_item_t s;
        int        kind;
        int        len;
        s.start_x = coord_t'($urandom_range(COORD_MAX));
        s.start_y = coord_t'($urandom_range(COORD_MAX));
        s.end_x   = coord_t'($urandom_range(COORD_MAX));
        s.end_y   = coord_t'($urandom_range(COORD_MAX));
        kind = $urandom_range(99);
        len  = $urandom_range(COORD_MAX);
        if (kind >= 45 && kind < 70)
        begin
            s.end_x = offset_coord(s.start_x, int'($urandom_range(10)) - 5);
            s.end_y = offset_coord(s.start_y, int'($urandom_range(10)) - 5);
        end
        else if (kind >= 70 && kind < 80)
        begin
            if ($urandom_range(1))
                s.end_y = s.start_y;
            else
                s.end_x = s.start_x;
        end
        else if (kind >= 80 && kind < 92)
        begin
            s.end_x = offset_coord(s.start_x, $urandom_range(1) ? len : -len);
            s.end_y = offset_coord(s.start_y, $urandom_range(1) ? len : -len);
        end
        else if (kind >= 92)
        begin
            s.end_x = s.start_x;
            s.end_y = s.start_y;
        end
        return s;
    endfunction

    // Driver: hold the current item until it is taken, then offer the next
    // one from the queue unless this cycle is picked to idle. Predict on accept.
    always @(posedge clk or negedge rst_n)
    begin : seg_driver
        seg_item_t next_seg;
        logic      next_valid;
        if (!rst_n)
        begin
            seg_valid <= 1'b0;
            seg       <= '0;
        end
        else
        begin
            next_valid = seg_valid;
            next_seg   = seg;
            if (seg_valid && seg_ready)
            begin
                rasterize_segment(seg);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_segs.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct)
            begin
                next_seg   = pending_segs.pop_front();
                next_valid = 1'b1;
            end
            seg_valid <= next_valid;
            seg       <= next_seg;
        end
    end

    // Monitor: check every accepted pixel against the oldest prediction,
    // then pick the next ready value.
    always @(posedge clk or negedge rst_n)
    begin : pix_monitor
        pix_item_t want;
        if (!rst_n)
            pix_ready <= 1'b0;
        else
        begin
            if (pix_valid && pix_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected pixel: x=%0d y=%0d octant=%0d last=%0b",
                                 pix.pixel_x, pix.pixel_y, pix.octant, pix.last);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix.pixel_x !== want.pixel_x || pix.pixel_y !== want.pixel_y ||
                        pix.octant !== want.octant || pix.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("pixel mismatch: expected x=%0d y=%0d octant=%0d last=%0b",
                                     want.pixel_x, want.pixel_y, want.octant, want.last);
                            $display("                got      x=%0d y=%0d octant=%0d last=%0b",
                                     pix.pixel_x, pix.pixel_y, pix.octant, pix.last);
                        end
                    end
                end
            end
            pix_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Count out the long hold-off once it has been requested.
    always @(posedge clk)
    begin
        if (long_stall_go && !long_stall_done)
        begin
            if (long_stall_count == LONG_STALL)
                long_stall_done <= 1'b1;
            else
                long_stall_count <= long_stall_count + 1;
        end
    end

    // Wait for every queued item to be taken and every predicted pixel to arrive.
    task automatic wait_drained();
        while (pending_segs.size() != 0 || seg_valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: directed segments, then random ones; slow receiver.
        // Zero-length segments at both corners of the tile.
        pending_segs.push_back(make_seg(0, 0, 0, 0));
        pending_segs.push_back(make_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        // Full-length exact diagonals in all four directions.
        pending_segs.push_back(make_seg(0, 0, COORD_MAX, COORD_MAX));
        pending_segs.push_back(make_seg(COORD_MAX, 0, 0, COORD_MAX));
        pending_segs.push_back(make_seg(COORD_MAX, COORD_MAX, 0, 0));
        pending_segs.push_back(make_seg(0, COORD_MAX, COORD_MAX, 0));
        // Full-length axial segments: right, left, up, down.
        pending_segs.push_back(make_seg(0, 5, COORD_MAX, 5));
        pending_segs.push_back(make_seg(COORD_MAX, 40, 0, 40));
        pending_segs.push_back(make_seg(7, 0, 7, COORD_MAX));
        pending_segs.push_back(make_seg(50, COORD_MAX, 50, 0));
        // Initial tie of the decision term in every zone (minor is half of major).
        pending_segs.push_back(make_seg(32, 32, 36, 34));
        pending_segs.push_back(make_seg(32, 32, 34, 36));
        pending_segs.push_back(make_seg(32, 32, 30, 36));
        pending_segs.push_back(make_seg(32, 32, 28, 34));
        pending_segs.push_back(make_seg(32, 32, 28, 30));
        pending_segs.push_back(make_seg(32, 32, 30, 28));
        pending_segs.push_back(make_seg(32, 32, 34, 28));
        pending_segs.push_back(make_seg(32, 32, 36, 30));
        // A nearly flat and a nearly diagonal full-tile segment.
        pending_segs.push_back(make_seg(0, 0, COORD_MAX, 1));
        pending_segs.push_back(make_seg(COORD_MAX, 1, 0, COORD_MAX));
        repeat (130) pending_segs.push_back(random_segment());
        wait_drained();

        // Phase two: slow sender, mostly ready receiver.
        tx_idle_pct = 70;
        rx_idle_pct = 29;
        repeat (120) pending_segs.push_back(random_segment());
        wait_drained();

        // Phase three: no idling on either side, opened by a long receiver
        // hold-off so the block backs up and drops seg_ready.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_stall_go = 1'b1;
        repeat (100) pending_segs.push_back(random_segment());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("midpoint_line_rasterizer_tb passed");
        else
            $display("midpoint_line_rasterizer_tb failed");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("midpoint_line_rasterizer_tb failed");
        $finish;
    end

endmodule

### files.f
hdl/mlr_pkg.sv
hdl/midpoint_line_rasterizer.sv
tb/midpoint_line_rasterizer_tb.sv
